// File: hw/rtl/nied_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nied_pkg
// Shared types, constants and helpers for the NEC IR edge decoder.
// ----------------------------------------------------------------------------
package nied_pkg;

  localparam int TIME_W   = 16;
  localparam int FRAME_W  = 32;
  localparam int BITS_W   = 6;
  localparam int REPEAT_W = 8;

  // Payload bits per frame; must stay within 8..32
  localparam int CODE_BITS = 32;
  localparam logic [BITS_W-1:0] CODE_COUNT = BITS_W'(CODE_BITS);

  localparam logic [REPEAT_W-1:0] REPEAT_MAX = '1;

  // Edge kinds
  localparam logic EDGE_RISING  = 1'b0;
  localparam logic EDGE_FALLING = 1'b1;

  // Status codes on the result channel
  localparam logic [1:0] STATUS_IDLE   = 2'd0;
  localparam logic [1:0] STATUS_LEADER = 2'd1;
  localparam logic [1:0] STATUS_DECODE = 2'd2;
  localparam logic [1:0] STATUS_READY  = 2'd3;

  // Notify codes
  localparam logic [1:0] NOTIFY_NONE   = 2'd0;
  localparam logic [1:0] NOTIFY_FRAME  = 2'd1;
  localparam logic [1:0] NOTIFY_REPEAT = 2'd2;

  // Interval is a 17-bit difference plus one wrap add: 18 bits signed
  typedef logic signed [17:0] interval_t;

  // Windows in 10 us ticks (exclusive bounds)
  localparam interval_t LEADER_LO = 18'sd800;
  localparam interval_t LEADER_HI = 18'sd1000;
  localparam interval_t START_LO  = 18'sd400;
  localparam interval_t START_HI  = 18'sd500;
  localparam interval_t REPEAT_LO = 18'sd200;
  localparam interval_t REPEAT_HI = 18'sd300;
  localparam interval_t ZERO_LO   = 18'sd0;
  localparam interval_t ZERO_HI   = 18'sd106;
  localparam interval_t ONE_LO    = 18'sd118;
  localparam interval_t ONE_HI    = 18'sd218;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_LEADER = 4'b0010,
    MODE_DECODE = 4'b0100,
    MODE_READY  = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic [TIME_W-1:0]    falling_time;
    logic [TIME_W-1:0]    prior_rising_time;
    logic [FRAME_W-1:0]   shift_code;
    logic [BITS_W-1:0]    bits_taken;
    logic [REPEAT_W-1:0]  repeat_count;
  } dec_state_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_code;
    logic [1:0]          decoder_status;
    logic [1:0]          notify;
    logic [REPEAT_W-1:0] repeat_total;
  } result_t;

  // Signed interval with one timer-period correction when negative
  function automatic interval_t interval_of(input logic [TIME_W-1:0] later,
                                            input logic [TIME_W-1:0] earlier,
                                            input logic [TIME_W-1:0] wrap);
    interval_t diff;
    diff = $signed({2'b00, later}) - $signed({2'b00, earlier});
    if (diff[17]) begin
      diff = diff + $signed({2'b00, wrap});
    end
    return diff;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/nied_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nied_if
// Valid/ready channels: edge events in, decoder results out.
// ----------------------------------------------------------------------------
interface nied_edge_if;
  logic                        valid;
  logic                        ready;
  logic                        edge_kind;
  logic [nied_pkg::TIME_W-1:0] edge_time;

  modport source (output valid, output edge_kind, output edge_time, input ready);
  modport sink   (input valid, input edge_kind, input edge_time, output ready);
endinterface

interface nied_result_if;
  logic                          valid;
  logic                          ready;
  logic [nied_pkg::FRAME_W-1:0]  frame_code;
  logic [1:0]                    decoder_status;
  logic [1:0]                    notify;
  logic [nied_pkg::REPEAT_W-1:0] repeat_total;

  modport source (output valid, output frame_code, output decoder_status,
                  output notify, output repeat_total, input ready);
  modport sink   (input valid, input frame_code, input decoder_status,
                  input notify, input repeat_total, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/nied_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nied_step
// Next-state and result logic for one edge event.
// ----------------------------------------------------------------------------
module nied_step (
  input  wire nied_pkg::dec_state_t          st,
  input  wire logic [nied_pkg::TIME_W-1:0]   wrap,
  input  wire logic                          edge_kind,
  input  wire logic [nied_pkg::TIME_W-1:0]   edge_time,
  output nied_pkg::dec_state_t               st_next,
  output nied_pkg::result_t                  res
);

  logic                            from_rest;
  logic [nied_pkg::TIME_W-1:0]     later;
  logic [nied_pkg::TIME_W-1:0]     earlier;
  nied_pkg::interval_t             d;
  logic [nied_pkg::BITS_W-1:0]     bits_inc;
  logic [nied_pkg::REPEAT_W-1:0]   rep_inc;
  logic [1:0]                      notify;
  logic [1:0]                      status;

  // Leader low is measured from the falling edge; other gaps are high times
  assign from_rest = (st.mode == nied_pkg::MODE_IDLE) ||
                     (st.mode == nied_pkg::MODE_READY);
  assign later     = from_rest ? edge_time : st.falling_time;
  assign earlier   = from_rest ? st.falling_time : st.prior_rising_time;
  assign d         = nied_pkg::interval_of(later, earlier, wrap);
  assign bits_inc  = st.bits_taken + nied_pkg::BITS_W'(1);
  assign rep_inc   = (st.repeat_count == nied_pkg::REPEAT_MAX) ?
                     st.repeat_count : st.repeat_count + nied_pkg::REPEAT_W'(1);

  always_comb begin
    st_next = st;
    notify  = nied_pkg::NOTIFY_NONE;
    if (edge_kind == nied_pkg::EDGE_FALLING) begin
      st_next.falling_time = edge_time;
    end else begin
      case (st.mode)
        nied_pkg::MODE_IDLE, nied_pkg::MODE_READY: begin
          if (d > nied_pkg::LEADER_LO && d < nied_pkg::LEADER_HI) begin
            st_next.mode = nied_pkg::MODE_LEADER;
          end
        end
        nied_pkg::MODE_LEADER: begin
          if (d > nied_pkg::START_LO && d < nied_pkg::START_HI) begin
            st_next.bits_taken   = '0;
            st_next.shift_code   = '0;
            st_next.repeat_count = '0;
            st_next.mode         = nied_pkg::MODE_DECODE;
          end else if (d > nied_pkg::REPEAT_LO && d < nied_pkg::REPEAT_HI) begin
            st_next.mode         = nied_pkg::MODE_READY;
            st_next.repeat_count = rep_inc;
            if (rep_inc > nied_pkg::REPEAT_W'(1)) begin
              notify = nied_pkg::NOTIFY_REPEAT;
            end
          end
        end
        nied_pkg::MODE_DECODE: begin
          st_next.shift_code = {st.shift_code[nied_pkg::FRAME_W-2:0], 1'b0};
          if (d > nied_pkg::ZERO_LO && d < nied_pkg::ZERO_HI) begin
            st_next.bits_taken = bits_inc;
          end else if (d > nied_pkg::ONE_LO && d < nied_pkg::ONE_HI) begin
            st_next.shift_code[0] = 1'b1;
            st_next.bits_taken    = bits_inc;
          end else begin
            // bad bit width: drop back to idle, count stays put
            st_next.mode = nied_pkg::MODE_IDLE;
          end
          if (st_next.mode == nied_pkg::MODE_DECODE &&
              bits_inc == nied_pkg::CODE_COUNT) begin
            st_next.mode = nied_pkg::MODE_READY;
            notify       = nied_pkg::NOTIFY_FRAME;
          end
        end
        default: begin
          st_next.mode = nied_pkg::MODE_IDLE;
        end
      endcase
      st_next.prior_rising_time = edge_time;
    end
  end

  always_comb begin
    case (st_next.mode)
      nied_pkg::MODE_IDLE:   status = nied_pkg::STATUS_IDLE;
      nied_pkg::MODE_LEADER: status = nied_pkg::STATUS_LEADER;
      nied_pkg::MODE_DECODE: status = nied_pkg::STATUS_DECODE;
      nied_pkg::MODE_READY:  status = nied_pkg::STATUS_READY;
      default:               status = nied_pkg::STATUS_IDLE;
    endcase
  end

  assign res.frame_code     = st_next.shift_code;
  assign res.decoder_status = status;
  assign res.notify         = notify;
  assign res.repeat_total   = st_next.repeat_count;

endmodule
`default_nettype wire

// File: hw/rtl/nec_ir_edge_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nec_ir_edge_decoder_unit
// NEC IR decoder working on timer-captured edge events.
// ----------------------------------------------------------------------------
// Usage:
//   events  - sink channel; each transaction is one captured edge
//             (edge_kind 1 = falling, 0 = rising) and its timer count.
//   results - source channel; exactly one transaction per event, carrying
//             the code register, decoder status, notify code and repeat count.
//   cfg_write_en / cfg_write_data - write the capture timer period
//             (counter_wrap, reset 65535); write only while the block is idle.
// Flow: an event is captured into the input register when accepted, and
//   its result is loaded into the output register when the input stage
//   advances, which waits while a held result is not taken.
// Throughput: one event per cycle while results are taken; the decoder state
//   update is a single subtract/add and window compare between the input and output registers.
// Reset (rst, synchronous): decoder goes idle, timestamps, code, bit count
//   and repeat count clear, both register stages empty.
// Stall: a held result keeps its register; the input register still takes
//   one event, and events stop only when both stages are full.
// ----------------------------------------------------------------------------
module nec_ir_edge_decoder_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write_en,
  input  wire logic [nied_pkg::TIME_W-1:0]  cfg_write_data,
  nied_edge_if.sink                         events,
  nied_result_if.source                     results
);

  // capture timer period
  logic [nied_pkg::TIME_W-1:0] counter_wrap;

  // input register stage
  logic                        in_valid;
  logic                        in_kind;
  logic [nied_pkg::TIME_W-1:0] in_time;

  // decoder state
  nied_pkg::dec_state_t        state;
  nied_pkg::dec_state_t        state_next;

  // output register stage
  logic                        out_valid;
  nied_pkg::result_t           out_res;
  nied_pkg::result_t           step_res;

  logic                        advance;

  // The input stage moves forward when the output register is empty or
  // its transaction is being taken this cycle.
  assign advance      = in_valid && (!out_valid || results.ready);
  assign events.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_wrap <= '1;
    end else if (cfg_write_en) begin
      counter_wrap <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (events.ready) begin
      in_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      in_kind <= events.edge_kind;
      in_time <= events.edge_time;
    end
  end

  nied_step u_step (
    .st        (state),
    .wrap      (counter_wrap),
    .edge_kind (in_kind),
    .edge_time (in_time),
    .st_next   (state_next),
    .res       (step_res)
  );

  // State commits only when the result is loaded, so it stays in step
  // with the results channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode              <= nied_pkg::MODE_IDLE;
      state.falling_time      <= '0;
      state.prior_rising_time <= '0;
      state.shift_code        <= '0;
      state.bits_taken        <= '0;
      state.repeat_count      <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign results.valid          = out_valid;
  assign results.frame_code     = out_res.frame_code;
  assign results.decoder_status = out_res.decoder_status;
  assign results.notify         = out_res.notify;
  assign results.repeat_total   = out_res.repeat_total;

  // A completed frame is always reported with data ready
  a_frame_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.notify == nied_pkg::NOTIFY_FRAME) |->
      (out_res.decoder_status == nied_pkg::STATUS_READY))
    else $error("frame notify without ready status");

  // A repeat notify means at least the second repeat since the frame
  a_repeat_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.notify == nied_pkg::NOTIFY_REPEAT) |->
      (out_res.repeat_total > nied_pkg::REPEAT_W'(1) &&
       out_res.decoder_status == nied_pkg::STATUS_READY))
    else $error("repeat notify with too few repeats");

  // Bit count never runs past a full frame
  a_bits_bound: assert property (@(posedge clk) disable iff (rst)
    state.bits_taken <= nied_pkg::CODE_COUNT)
    else $error("bit count beyond frame length");

  // With no pending result, the input side can never be blocked
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> events.ready)
    else $error("events stalled with empty output register");

endmodule
`default_nettype wire
